### hw/rtl/tht_pkg.sv
// ----------------------------------------------------------------------------
// tht_pkg: shared types and constants for the triangle hit test unit
// Opcode codes, field widths, CSR indices and window reset values.
// ----------------------------------------------------------------------------
package tht_pkg;

   localparam int MAX_TRIANGLES_DEF = 64;
   localparam int COORD_BITS_DEF    = 16;
   localparam int FIELD_W           = 16;
   localparam int PIX_W             = 12;
   localparam int WIN_W             = 13;
   localparam int CSR_IDX_W         = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WIN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_HEIGHT = 1'b1;

   localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 13'd1024;
   localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 13'd768;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

endpackage

### hw/rtl/tht_req_if.sv
// ----------------------------------------------------------------------------
// tht_req_if: request channel of the triangle hit test unit
// Valid/ready handshake carrying an opcode, three vertices and a pixel.
// ----------------------------------------------------------------------------
interface tht_req_if;
   import tht_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic signed [FIELD_W-1:0] ax;
   logic signed [FIELD_W-1:0] ay;
   logic signed [FIELD_W-1:0] bx;
   logic signed [FIELD_W-1:0] by;
   logic signed [FIELD_W-1:0] cx;
   logic signed [FIELD_W-1:0] cy;
   logic [PIX_W-1:0]          mouse_x;
   logic [PIX_W-1:0]          mouse_y;

   modport source (output valid, opcode, ax, ay, bx, by, cx, cy, mouse_x, mouse_y,
                   input ready);
   modport sink   (input valid, opcode, ax, ay, bx, by, cx, cy, mouse_x, mouse_y,
                   output ready);
endinterface

### hw/rtl/tht_rsp_if.sv
// ----------------------------------------------------------------------------
// tht_rsp_if: result channel of the triangle hit test unit
// Valid/ready handshake carrying the hit flag and the append status.
// ----------------------------------------------------------------------------
interface tht_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic status;

   modport source (output valid, hit, status, input ready);
   modport sink   (input valid, hit, status, output ready);
endinterface

### hw/rtl/triangle_hit_test_unit.sv
// ----------------------------------------------------------------------------
// triangle_hit_test_unit: 2D triangle table with point hit test
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
// Every item returns exactly one result. A query runs through the front end
// (two restoring dividers, one quotient bit per cycle) and then walks the
// table in the back end at one triangle per cycle through a read/edge/
// multiply/sign pipeline, stopping early on the first hit. The vertex
// memory's single read port sets the walk rate. The front end can prepare
// the next item while the back end walks.
module triangle_hit_test_unit
   import tht_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tht_req_if.sink          req,
   tht_rsp_if.source        rsp,
   input  logic             csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIN_W-1:0] csr_write_data
);
   localparam int PT_W = COORD_BITS + 12;
   localparam int CMD_W = 2 + 6 * COORD_BITS + 2 * PT_W;

   logic [WIN_W-1:0] win_width_ff, win_height_ff;
   logic             f_valid, f_ready, b_valid, b_ready, b_busy;
   logic [1:0]       f_op, b_op;
   logic [6*COORD_BITS-1:0] f_vt, b_vt, in_vt;
   logic signed [PT_W-1:0]  f_px, f_py, b_px, b_py;
   logic [CMD_W-1:0] b_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_width_ff  <= WIN_WIDTH_RST;
         win_height_ff <= WIN_HEIGHT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIN_WIDTH:  win_width_ff  <= csr_write_data;
            CSR_WIN_HEIGHT: win_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign in_vt = {req.ax[COORD_BITS-1:0], req.ay[COORD_BITS-1:0],
                   req.bx[COORD_BITS-1:0], req.by[COORD_BITS-1:0],
                   req.cx[COORD_BITS-1:0], req.cy[COORD_BITS-1:0]};

   tht_front #(.COORD_BITS(COORD_BITS), .PT_W(PT_W)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_opcode(req.opcode),
      .in_verts(in_vt), .in_mx(req.mouse_x), .in_my(req.mouse_y),
      .win_width(win_width_ff), .win_height(win_height_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_opcode(f_op),
      .out_verts(f_vt), .out_px(f_px), .out_py(f_py)
   );

   tht_queue #(.W(CMD_W)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_op, f_vt, f_px, f_py}),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   assign {b_op, b_vt, b_px, b_py} = b_data;

   tht_back #(.MAX_TRIANGLES(MAX_TRIANGLES), .COORD_BITS(COORD_BITS),
              .PT_W(PT_W)) u_back (
      .clock, .reset,
      .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_opcode(b_op),
      .cmd_verts(b_vt), .cmd_px(b_px), .cmd_py(b_py),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
      .rsp_status(rsp.status), .busy(b_busy)
   );

   // a result is only offered while the back end holds a command
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> b_busy) else $error("result without command");
   // status only flags an append
   a_no_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.hit && rsp.status)) else $error("hit and status");
   // the back end takes no new command while it is busy
   a_back_hold: assert property (@(posedge clock) disable iff (reset)
      b_busy |-> !b_ready) else $error("back end accepted while busy");
endmodule

### hw/rtl/tht_front.sv
// ----------------------------------------------------------------------------
// tht_front: command intake and pixel normalization
// Accepts items, computes the query point with two restoring dividers and
// pushes one command word into the queue.
// ----------------------------------------------------------------------------
module tht_front
   import tht_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int PT_W       = COORD_BITS + 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [1:0]             in_opcode,
   input  logic [6*COORD_BITS-1:0] in_verts,
   input  logic [PIX_W-1:0]       in_mx,
   input  logic [PIX_W-1:0]       in_my,
   input  logic [WIN_W-1:0]       win_width,
   input  logic [WIN_W-1:0]       win_height,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [1:0]             out_opcode,
   output logic [6*COORD_BITS-1:0] out_verts,
   output logic signed [PT_W-1:0] out_px,
   output logic signed [PT_W-1:0] out_py
);
   // dividend 2*m*one: PIX_W + COORD_BITS - 1 bits
   localparam int NUM_W = PIX_W + COORD_BITS - 1;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic signed [PT_W-1:0] ONE = PT_W'(1) << (COORD_BITS - 2);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0]       qx_ff, qx_in, qy_ff, qy_in;
   logic [WIN_W:0]         rx_ff, rx_in, ry_ff, ry_in;
   logic [WIN_W-1:0]       dw_ff, dw_in, dh_ff, dh_in;
   logic [1:0]             op_ff, op_in;
   logic [6*COORD_BITS-1:0] vt_ff, vt_in;
   logic [WIN_W:0]         tx, ty;

   assign in_ready   = (state_ff == S_IDLE);
   assign out_valid  = (state_ff == S_OUT);
   assign out_opcode = op_ff;
   assign out_verts  = vt_ff;
   assign out_px = signed'(PT_W'(qx_ff)) - ONE;
   assign out_py = ONE - signed'(PT_W'(qy_ff));

   // one quotient bit per cycle for x and y
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      rx_in = rx_ff; ry_in = ry_ff;
      dw_in = dw_ff; dh_in = dh_ff;
      op_in = op_ff; vt_in = vt_ff;
      tx = {rx_ff[WIN_W-1:0], qx_ff[NUM_W-1]};
      ty = {ry_ff[WIN_W-1:0], qy_ff[NUM_W-1]};
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in = in_opcode;
               vt_in = in_verts;
               qx_in = NUM_W'(in_mx) << (COORD_BITS - 1);
               qy_in = NUM_W'(in_my) << (COORD_BITS - 1);
               rx_in = '0; ry_in = '0;
               dw_in = (win_width  == '0) ? WIN_W'(1) : win_width;
               dh_in = (win_height == '0) ? WIN_W'(1) : win_height;
               cnt_in = '0;
               state_in = (in_opcode == OP_QUERY) ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (tx >= {1'b0, dw_ff}) begin
               rx_in = tx - {1'b0, dw_ff};
               qx_in = {qx_ff[NUM_W-2:0], 1'b1};
            end else begin
               rx_in = tx;
               qx_in = {qx_ff[NUM_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, dh_ff}) begin
               ry_in = ty - {1'b0, dh_ff};
               qy_in = {qy_ff[NUM_W-2:0], 1'b1};
            end else begin
               ry_in = ty;
               qy_in = {qy_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      qx_ff <= qx_in; qy_ff <= qy_in;
      rx_ff <= rx_in; ry_ff <= ry_in;
      dw_ff <= dw_in; dh_ff <= dh_in;
      op_ff <= op_in; vt_ff <= vt_in;
   end
endmodule

### hw/rtl/tht_queue.sv
// ----------------------------------------------------------------------------
// tht_queue: two-entry command queue between front and back
// Decouples the intake from the table walk.
// ----------------------------------------------------------------------------
module tht_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

### hw/rtl/tht_back.sv
// ----------------------------------------------------------------------------
// tht_back: triangle table and hit walk
// Holds the vertex memory, executes clear/append and walks the table for a
// query through a read / edge / cross-product / sign pipeline.
// ----------------------------------------------------------------------------
module tht_back
   import tht_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF,
   parameter int PT_W          = COORD_BITS + 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  logic [1:0]              cmd_opcode,
   input  logic [6*COORD_BITS-1:0] cmd_verts,
   input  logic signed [PT_W-1:0]  cmd_px,
   input  logic signed [PT_W-1:0]  cmd_py,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic                    rsp_status,
   output logic                    busy
);
   localparam int AW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CW  = $clog2(MAX_TRIANGLES + 1);
   localparam int EW  = COORD_BITS + 1;          // vertex difference
   localparam int QW  = PT_W + 1;                // point minus vertex
   localparam int DW  = 2 * EW + 1;              // cross of edges
   localparam int VW  = QW + EW + 1;             // cross with point
   localparam int SW  = VW + 2;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_OUT} state_type;

   logic [6*COORD_BITS-1:0] mem [MAX_TRIANGLES];

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               hit_ff, hit_in, status_ff, status_in;
   logic signed [PT_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [3:0]         vld_ff;   // read, edge, cross, sign stage valids
   logic               rd_en;
   logic [6*COORD_BITS-1:0] rd_ff;

   // stage 2: edges
   logic signed [EW-1:0] e0x_ff, e0y_ff, e1x_ff, e1y_ff;
   logic signed [QW-1:0] qx_ff, qy_ff;
   // stage 3: products
   logic signed [DW-1:0] m0_ff, m1_ff;
   logic signed [VW-1:0] v0_ff, v1_ff, w0_ff, w1_ff;
   // stage 4: sign test
   logic                 tri_hit_ff;

   logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
   logic signed [DW-1:0] d_c;
   logic signed [VW-1:0] vn_c, wn_c;
   logic signed [SW-1:0] r_c;
   logic                 walk_done;

   assign cmd_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign rsp_hit    = hit_ff;
   assign rsp_status = status_ff;
   assign busy       = (state_ff != S_IDLE);

   assign {ax, ay, bx, by, cx, cy} = rd_ff;
   assign rd_en = (state_ff == S_WALK) && (idx_ff < count_ff) && !hit_ff;
   assign walk_done = (state_ff == S_WALK) && (hit_ff || ((idx_ff >= count_ff)
                      && (vld_ff == 4'd0)));

   // control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      status_in = status_ff;
      px_in = px_ff; py_in = py_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               hit_in = 1'b0;
               status_in = 1'b0;
               state_in = S_OUT;
               case (cmd_opcode)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (count_ff >= CW'(MAX_TRIANGLES)) status_in = 1'b1;
                     else count_in = count_ff + CW'(1);
                  end
                  OP_QUERY: begin
                     idx_in = '0;
                     px_in = cmd_px; py_in = cmd_py;
                     state_in = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (rd_en) idx_in = idx_ff + CW'(1);
            if (vld_ff[3] && tri_hit_ff) hit_in = 1'b1;
            if (walk_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         vld_ff <= '0;
         hit_ff <= 1'b0;
         status_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hit_ff <= hit_in;
         status_ff <= status_in;
         vld_ff <= walk_done ? 4'd0 : {vld_ff[2:0], rd_en};
      end
      idx_ff <= idx_in;
      px_ff <= px_in; py_ff <= py_in;
   end

   // vertex memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && cmd_valid && cmd_opcode == OP_APPEND
          && count_ff < CW'(MAX_TRIANGLES))
         mem[count_ff[AW-1:0]] <= cmd_verts;
      if (rd_en) rd_ff <= mem[idx_ff[AW-1:0]];
   end

   // edge vectors and point offset
   always_ff @(posedge clock) begin
      e0x_ff <= EW'(bx) - EW'(ax);
      e0y_ff <= EW'(by) - EW'(ay);
      e1x_ff <= EW'(cx) - EW'(ax);
      e1y_ff <= EW'(cy) - EW'(ay);
      qx_ff  <= QW'(px_ff) - QW'(ax);
      qy_ff  <= QW'(py_ff) - QW'(ay);
   end

   // partial products, one multiplier each
   always_ff @(posedge clock) begin
      m0_ff <= DW'(e0x_ff) * DW'(e1y_ff);
      m1_ff <= DW'(e0y_ff) * DW'(e1x_ff);
      v0_ff <= VW'(qx_ff) * VW'(e1y_ff);
      v1_ff <= VW'(qy_ff) * VW'(e1x_ff);
      w0_ff <= VW'(e0x_ff) * VW'(qy_ff);
      w1_ff <= VW'(e0y_ff) * VW'(qx_ff);
   end

   // sign tests
   always_comb begin
      d_c  = m0_ff - m1_ff;
      vn_c = v0_ff - v1_ff;
      wn_c = w0_ff - w1_ff;
      r_c  = SW'(d_c) - SW'(vn_c) - SW'(wn_c);
   end

   always_ff @(posedge clock) begin
      tri_hit_ff <= (d_c != '0)
         && ((vn_c == '0) || ((vn_c < 0) == (d_c < 0)))
         && ((wn_c == '0) || ((wn_c < 0) == (d_c < 0)))
         && ((r_c  == '0) || ((r_c  < 0) == (d_c < 0)));
   end
endmodule

### tb/tht_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tht_tb_if: bench-side item records for the triangle hit test unit
// The block's own request and result interfaces are driven directly.
// ----------------------------------------------------------------------------
package tht_tb_pkg;
   import tht_pkg::*;

   // one request item as the bench tracks it
   typedef struct {
      opcode_type                op;
      logic signed [FIELD_W-1:0] ax, ay, bx, by, cx, cy;
      logic [PIX_W-1:0]          mx, my;
   } tri_req_type;

   // one expected result item
   typedef struct {
      logic hit;
      logic status;
   } tri_rsp_type;
endpackage

### tb/triangle_hit_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_hit_test_unit_tb: self-checking bench for the triangle hit test
// Drives clear/append/query/nop items with random gaps, predicts hit and status
// with an in-bench triangle table, and checks every result in order.
// ----------------------------------------------------------------------------
module triangle_hit_test_unit_tb;
   import tht_pkg::*;
   import tht_tb_pkg::*;

   localparam int DEPTH = MAX_TRIANGLES_DEF;
   localparam int ONE   = 1 << (COORD_BITS_DEF - 2);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WIN_W-1:0] csr_write_data = '0;

   tht_req_if req ();
   tht_rsp_if rsp ();

   triangle_hit_test_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // predictor state
   longint tri_x[DEPTH][3];
   longint tri_y[DEPTH][3];
   int     tri_count;
   longint win_w, win_h;
   tri_rsp_type pending_rsp[$];
   int     errors = 0;

   function automatic int sgn(longint v);
      return (v > 0) - (v < 0);
   endfunction

   function automatic bit covers(int k, longint px, longint py);
      longint e0x, e0y, e1x, e1y, qx, qy, d, vn, wn;
      e0x = tri_x[k][1] - tri_x[k][0];
      e0y = tri_y[k][1] - tri_y[k][0];
      e1x = tri_x[k][2] - tri_x[k][0];
      e1y = tri_y[k][2] - tri_y[k][0];
      qx  = px - tri_x[k][0];
      qy  = py - tri_y[k][0];
      d   = e0x * e1y - e0y * e1x;
      if (d == 0) return 1'b0;
      vn = qx * e1y - qy * e1x;
      wn = e0x * qy - e0y * qx;
      return sgn(d) * sgn(vn) >= 0 && sgn(d) * sgn(wn) >= 0 &&
             sgn(d) * sgn(d - vn - wn) >= 0;
   endfunction

   function automatic tri_rsp_type predict_hit(tri_req_type it);
      tri_rsp_type r;
      longint w, h, px, py;
      r.hit = 1'b0;
      r.status = 1'b0;
      case (it.op)
         OP_CLEAR: tri_count = 0;
         OP_APPEND: begin
            if (tri_count >= DEPTH) r.status = 1'b1;
            else begin
               tri_x[tri_count][0] = it.ax; tri_y[tri_count][0] = it.ay;
               tri_x[tri_count][1] = it.bx; tri_y[tri_count][1] = it.by;
               tri_x[tri_count][2] = it.cx; tri_y[tri_count][2] = it.cy;
               tri_count++;
            end
         end
         OP_QUERY: begin
            w  = (win_w == 0) ? 1 : win_w;
            h  = (win_h == 0) ? 1 : win_h;
            px = (2 * longint'(it.mx) * ONE) / w - ONE;
            py = ONE - (2 * longint'(it.my) * ONE) / h;
            for (int k = 0; k < tri_count; k++)
               if (covers(k, px, py)) begin
                  r.hit = 1'b1;
                  break;
               end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   bit calm = 1'b0;  // stretch with no idling

   task automatic send_item(tri_req_type it);
      int g;
      g = calm ? 0 : gap_len();
      repeat (g) @(negedge clock);
      req.valid   = 1'b1;
      req.opcode  = it.op;
      req.ax = it.ax; req.ay = it.ay; req.bx = it.bx;
      req.by = it.by; req.cx = it.cx; req.cy = it.cy;
      req.mouse_x = it.mx; req.mouse_y = it.my;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(predict_hit(it));
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // sink side: random stalls, compare in order
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready = calm ? 1'b1 : (gap_len() == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result hit=%0b status=%0b", $time,
                     rsp.hit, rsp.status);
            errors++;
         end else begin
            tri_rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp.hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp.hit);
               errors++;
            end
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time,
                        want.status, rsp.status);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DEPTH + 40) @(negedge clock);
   endtask

   task automatic write_window(longint w, longint h);
      @(negedge clock);
      csr_write_enable = 1'b1; csr_index = CSR_WIN_WIDTH; csr_write_data = w[WIN_W-1:0];
      @(negedge clock);
      csr_index = CSR_WIN_HEIGHT; csr_write_data = h[WIN_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      win_w = w[WIN_W-1:0];
      win_h = h[WIN_W-1:0];
   endtask

   function automatic tri_req_type make_item(opcode_type op);
      tri_req_type it;
      it.op = op;
      it.ax = FIELD_W'($urandom); it.ay = FIELD_W'($urandom);
      it.bx = FIELD_W'($urandom); it.by = FIELD_W'($urandom);
      it.cx = FIELD_W'($urandom); it.cy = FIELD_W'($urandom);
      it.mx = PIX_W'($urandom);   it.my = PIX_W'($urandom);
      return it;
   endfunction

   // triangle near the point a query will likely land on
   function automatic tri_req_type big_triangle();
      tri_req_type it;
      it = make_item(OP_APPEND);
      it.ax = FIELD_W'(-$urandom_range(4000, 32768));
      it.ay = FIELD_W'(-$urandom_range(4000, 32768));
      it.bx = FIELD_W'($urandom_range(4000, 32767));
      it.by = FIELD_W'(-$urandom_range(0, 32768));
      it.cx = FIELD_W'($urandom_range(0, 20000) - 10000);
      it.cy = FIELD_W'($urandom_range(4000, 32767));
      if ($urandom_range(0, 1)) begin
         it.bx = it.cx; it.by = it.cy;
         it.cx = FIELD_W'($urandom_range(4000, 32767));
         it.cy = FIELD_W'(-$urandom_range(0, 32768));
      end
      return it;
   endfunction

   task automatic test_directed();
      tri_req_type it;
      it = make_item(OP_QUERY);                // empty table
      send_item(it);
      it = make_item(OP_APPEND);               // extreme vertices
      it.ax = 16'sh8000; it.ay = 16'sh8000; it.bx = 16'sh7fff;
      it.by = 16'sh8000; it.cx = 16'sh0000; it.cy = 16'sh7fff;
      send_item(it);
      it = make_item(OP_APPEND);               // degenerate
      it.ax = 16'sd0; it.ay = 16'sd0; it.bx = 16'sd100; it.by = 16'sd100;
      it.cx = 16'sd200; it.cy = 16'sd200;
      send_item(it);
      it = make_item(OP_QUERY); it.mx = 12'd0;    it.my = 12'd0;    send_item(it);
      it = make_item(OP_QUERY); it.mx = 12'hfff;  it.my = 12'hfff;  send_item(it);
      it = make_item(OP_QUERY); it.mx = 12'd512;  it.my = 12'd384;  send_item(it);
      it = make_item(OP_QUERY); it.mx = 12'd1024; it.my = 12'd0;    send_item(it);
      it = make_item(OP_NOP);   send_item(it);
      it = make_item(OP_CLEAR); send_item(it);
      it = make_item(OP_QUERY); it.mx = 12'd512; it.my = 12'd384; send_item(it);
   endtask

   task automatic test_table_full();
      send_item(make_item(OP_CLEAR));
      for (int k = 0; k < DEPTH + 3; k++) send_item(big_triangle());
      for (int k = 0; k < 4; k++) send_item(make_item(OP_QUERY));
      send_item(make_item(OP_CLEAR));
   endtask

   task automatic test_random(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3) send_item(make_item(OP_CLEAR));
         else if (r < 35) send_item(($urandom_range(0, 3) == 0) ?
                                    make_item(OP_APPEND) : big_triangle());
         else if (r < 97) send_item(make_item(OP_QUERY));
         else send_item(make_item(OP_NOP));
         if (k % 100 == 50) calm = ~calm;
      end
      calm = 1'b0;
   endtask

   initial begin
      // request driver defaults
      req.valid = 1'b0; req.opcode = OP_NOP;
      req.ax = '0; req.ay = '0; req.bx = '0; req.by = '0; req.cx = '0; req.cy = '0;
      req.mouse_x = '0; req.mouse_y = '0;
      tri_count = 0;
      win_w = WIN_WIDTH_RST;
      win_h = WIN_HEIGHT_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      drain();
      write_window(1, 1);
      test_table_full();
      drain();
      write_window(0, 8191);
      test_random(150);
      drain();
      write_window(4096, 4096);
      test_random(200);
      drain();
      write_window(640, 480);
      test_random(350);
      drain();
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule

### filelist.f
hw/rtl/tht_pkg.sv
hw/rtl/tht_req_if.sv
hw/rtl/tht_rsp_if.sv
hw/rtl/tht_front.sv
hw/rtl/tht_queue.sv
hw/rtl/tht_back.sv
hw/rtl/triangle_hit_test_unit.sv
tb/tht_tb_if.sv
tb/triangle_hit_test_unit_tb.sv
